/* hw/rtl/earp_pkg.sv */
package earp_pkg;

	localparam int MAX_BUFFER = 16384;
	// Holds byte counts up to MAX_BUFFER + 1, where the count saturates.
	localparam int POS_W = $clog2(MAX_BUFFER + 2);
	// Wide enough for 8 plus a 16-bit region length.
	localparam int REGION_W = 17;
	localparam int HEADER_BYTES = 12;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [31:0] TAG_RESET = 32'h8000_001B;
	localparam logic [31:0] VERSION_RESET = 32'd3;

	localparam logic REG_TAG = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	localparam logic KIND_UNIT = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic SEL_FAMILY = 1'b0;
	localparam logic SEL_TARGET = 1'b1;

	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_SHORT    = 3'd1,
		VERDICT_TAG      = 3'd2,
		VERDICT_LENGTH   = 3'd3,
		VERDICT_VERSION  = 3'd4,
		VERDICT_STRINGS  = 3'd5,
		VERDICT_TOO_LONG = 3'd6
	} verdict_t;

	// One queue entry: everything a single input byte produces.
	typedef struct packed {
		logic        has_unit;
		logic [15:0] unit;
		logic        sel;
		logic        has_verdict;
		verdict_t    verdict;
	} item_t;

endpackage

/* hw/rtl/earp_front.sv */
module earp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [31:0]         expected_tag,
	input  logic [31:0]         expected_version,
	output logic                q_push,
	output earp_pkg::item_t     q_item
);

	localparam logic [earp_pkg::POS_W-1:0] POS_MAX = earp_pkg::POS_W'(earp_pkg::MAX_BUFFER);
	localparam logic [earp_pkg::POS_W-1:0] POS_HDR = earp_pkg::POS_W'(earp_pkg::HEADER_BYTES);

	logic [earp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [15:0] len_q, len_d;
	logic [31:0] ver_q, ver_d;
	logic [7:0]  hold_q, hold_d;
	logic [2:0]  done_q, done_d;
	logic        nonempty_q, nonempty_d;
	logic        bad_q, bad_d;

	logic        accept;
	logic        in_region;
	logic [15:0] unit;
	logic        unit_fire;
	logic [earp_pkg::REGION_W-1:0] count_x;
	earp_pkg::verdict_t verdict_d;

	assign accept = push && !q_full;
	assign unit = {data_byte, hold_q};
	assign in_region = (pos_q >= POS_HDR) &&
		(earp_pkg::REGION_W'(pos_q) < earp_pkg::REGION_W'(len_q) + earp_pkg::REGION_W'(8));

	always_comb begin
		tag_d = tag_q;
		len_d = len_q;
		ver_d = ver_q;
		hold_d = hold_q;
		done_d = done_q;
		nonempty_d = nonempty_q;
		bad_d = bad_q;
		unit_fire = 1'b0;
		if (pos_q < earp_pkg::POS_W'(4)) begin
			tag_d = tag_q | ({24'd0, data_byte} << {pos_q[1:0], 3'b000});
		end else if (pos_q < earp_pkg::POS_W'(6)) begin
			len_d = len_q | ({8'd0, data_byte} << {pos_q[0], 3'b000});
		end else if (pos_q >= earp_pkg::POS_W'(8) && pos_q < POS_HDR) begin
			ver_d = ver_q | ({24'd0, data_byte} << {pos_q[1:0], 3'b000});
		end else if (in_region) begin
			// The region starts at an even offset, so bit 0 tells low from high byte.
			if (!pos_q[0]) begin
				hold_d = data_byte;
			end else if (done_q >= 3'd4) begin
				bad_d = 1'b1;
			end else if (unit == 16'd0) begin
				if (!nonempty_q) begin
					bad_d = 1'b1;
				end
				done_d = done_q + 3'd1;
				nonempty_d = 1'b0;
			end else begin
				nonempty_d = 1'b1;
				unit_fire = (done_q == 3'd0) || (done_q == 3'd2);
			end
		end
	end

	assign pos_d = (pos_q <= POS_MAX) ? pos_q + earp_pkg::POS_W'(1) : pos_q;
	assign count_x = earp_pkg::REGION_W'(pos_d);

	always_comb begin
		if (pos_d > POS_MAX) begin
			verdict_d = earp_pkg::VERDICT_TOO_LONG;
		end else if (pos_d < POS_HDR) begin
			verdict_d = earp_pkg::VERDICT_SHORT;
		end else if (tag_d != expected_tag) begin
			verdict_d = earp_pkg::VERDICT_TAG;
		end else if ((earp_pkg::REGION_W'(len_d) > count_x - earp_pkg::REGION_W'(8)) ||
				(len_d < 16'd4) || len_d[0]) begin
			verdict_d = earp_pkg::VERDICT_LENGTH;
		end else if (ver_d != expected_version) begin
			verdict_d = earp_pkg::VERDICT_VERSION;
		end else if (bad_d || (done_d < 3'd4)) begin
			verdict_d = earp_pkg::VERDICT_STRINGS;
		end else begin
			verdict_d = earp_pkg::VERDICT_OK;
		end
	end

	assign q_push = accept && (unit_fire || last_byte);

	always_comb begin
		q_item.has_unit = unit_fire;
		q_item.unit = unit;
		q_item.sel = (done_q == 3'd2) ? earp_pkg::SEL_TARGET : earp_pkg::SEL_FAMILY;
		q_item.has_verdict = last_byte;
		q_item.verdict = verdict_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			tag_q <= '0;
			len_q <= '0;
			ver_q <= '0;
			hold_q <= '0;
			done_q <= '0;
			nonempty_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
				tag_q <= '0;
				len_q <= '0;
				ver_q <= '0;
				hold_q <= '0;
				done_q <= '0;
				nonempty_q <= 1'b0;
				bad_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				tag_q <= tag_d;
				len_q <= len_d;
				ver_q <= ver_d;
				hold_q <= hold_d;
				done_q <= done_d;
				nonempty_q <= nonempty_d;
				bad_q <= bad_d;
			end
		end
	end

endmodule

/* hw/rtl/earp_queue.sv */
module earp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  earp_pkg::item_t wr_item,
	input  logic            rd_en,
	output earp_pkg::item_t head,
	output logic            q_empty,
	output logic            q_full
);

	earp_pkg::item_t slot_q [earp_pkg::QDEPTH];
	logic [earp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [earp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [earp_pkg::QCNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign q_empty = (cnt_q == '0);
	assign q_full = (cnt_q == earp_pkg::QCNT_W'(earp_pkg::QDEPTH));
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + earp_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + earp_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + earp_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - earp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/earp_back.sv */
module earp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  earp_pkg::item_t head,
	input  logic            q_empty,
	input  logic            pop,
	output logic            q_pop,
	output logic            empty,
	output logic            result_kind,
	output logic [15:0]     code_unit,
	output logic            string_select,
	output logic [2:0]      verdict,
	output logic            end_of_run
);

	logic unit_done_q;
	logic show_unit;
	logic take;

	assign show_unit = head.has_unit && !unit_done_q;
	assign empty = q_empty;
	assign take = pop && !q_empty;
	// An entry holding both a unit and a verdict is shown twice before it leaves.
	assign q_pop = take && !(show_unit && head.has_verdict);

	always_comb begin
		if (show_unit) begin
			result_kind = earp_pkg::KIND_UNIT;
			code_unit = head.unit;
			string_select = head.sel;
			verdict = earp_pkg::VERDICT_OK;
			end_of_run = !head.has_verdict;
		end else begin
			result_kind = earp_pkg::KIND_VERDICT;
			code_unit = 16'd0;
			string_select = earp_pkg::SEL_FAMILY;
			verdict = head.verdict;
			end_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_done_q <= 1'b0;
		end else if (take) begin
			unit_done_q <= show_unit && head.has_verdict;
		end
	end

endmodule

/* hw/rtl/exec_alias_record_parser.sv */
// Result items are registered in the queue before they reach the result ports.
// Throughput: one input byte per cycle while not full; the byte parser updates its counters.
// A final byte that also completes a code unit yields two result items, each taken by its own pop.
// A four-entry queue between the parser and the result stage absorbs output stalls.
// Reset (arst_n low, asynchronous) clears the parser state and the queue and restores
// expected_tag to 0x8000001B and expected_version to 3.
module exec_alias_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	// Input byte stream.
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// Result stream.
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [15:0] code_unit,
	output logic        string_select,
	output logic [2:0]  verdict,
	output logic        end_of_run,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] exp_tag_q;
	logic [31:0] exp_ver_q;
	logic        cfg_wr;
	logic        reg_idx;

	logic            q_push;
	earp_pkg::item_t q_item;
	earp_pkg::item_t q_head;
	logic            q_empty;
	logic            q_pop;

	// The two registers are word aligned; bit 2 of the address picks one of them.
	assign reg_idx = paddr[2];
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (reg_idx == earp_pkg::REG_VERSION) ? exp_ver_q : exp_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_tag_q <= earp_pkg::TAG_RESET;
			exp_ver_q <= earp_pkg::VERSION_RESET;
		end else if (cfg_wr) begin
			if (reg_idx == earp_pkg::REG_TAG) begin
				exp_tag_q <= pwdata;
			end else begin
				exp_ver_q <= pwdata;
			end
		end
	end

	// The front end parses each byte as it arrives. Bytes that complete a code unit of
	// the family name or target path, and the final byte of a record, leave one queue
	// entry carrying the unit, the verdict, or both. Other bytes only update the state.
	earp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.q_full           (full),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.expected_tag     (exp_tag_q),
		.expected_version (exp_ver_q),
		.q_push           (q_push),
		.q_item           (q_item)
	);

	// The queue is the registered boundary between both sides, so a stalled consumer
	// does not hold up the parser until the queue fills.
	earp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_item),
		.rd_en   (q_pop),
		.head    (q_head),
		.q_empty (q_empty),
		.q_full  (full)
	);

	// The back end turns each queue entry into one or two result items.
	earp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_empty       (q_empty),
		.pop           (pop),
		.q_pop         (q_pop),
		.empty         (empty),
		.result_kind   (result_kind),
		.code_unit     (code_unit),
		.string_select (string_select),
		.verdict       (verdict),
		.end_of_run    (end_of_run)
	);

endmodule

/* hw/rtl/earp_checker.sv */
module earp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        result_kind,
	input logic [15:0] code_unit,
	input logic        string_select,
	input logic [2:0]  verdict,
	input logic        end_of_run
);

	// A verdict always closes the run of results for its byte and carries no unit.
	a_verdict_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == earp_pkg::KIND_VERDICT) |->
			(end_of_run && code_unit == 16'd0 && string_select == earp_pkg::SEL_FAMILY))
		else $error("verdict item malformed");

	// A code unit never carries a verdict and is never the zero terminator.
	a_unit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == earp_pkg::KIND_UNIT) |->
			(verdict == earp_pkg::VERDICT_OK && code_unit != 16'd0))
		else $error("code unit item malformed");

	// A unit that does not end its run is followed at once by the verdict of that byte.
	a_unit_then_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && result_kind == earp_pkg::KIND_UNIT && !end_of_run) |=>
			(!empty && result_kind == earp_pkg::KIND_VERDICT))
		else $error("verdict missing after unit");

	// A waiting result holds while it is not taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
			(!empty && $stable(result_kind) && $stable(code_unit) && $stable(verdict)))
		else $error("waiting result changed");

endmodule

bind exec_alias_record_parser earp_checker u_earp_checker (.*);

/* tb/exec_alias_record_parser_test.sv */
module exec_alias_record_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One result item as the parser should produce it.
	typedef struct packed {
		logic                kind;
		logic [15:0]         unit;
		logic                sel;
		earp_pkg::verdict_t  verd;
		logic                eor;
	} parse_result_t;

	typedef logic [7:0] byte_list_t[$];

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic        result_kind;
	logic [15:0] code_unit;
	logic        string_select;
	logic [2:0]  verdict;
	logic        end_of_run;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	exec_alias_record_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.code_unit    (code_unit),
		.string_select(string_select),
		.verdict      (verdict),
		.end_of_run   (end_of_run),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Results the parser owes us, oldest first.
	parse_result_t parsed_results_q[$];

	// Our own copy of the parser state and of the two registers.
	logic [16:0] rec_pos;
	logic [31:0] rec_tag;
	logic [15:0] rec_len;
	logic [31:0] rec_version;
	logic [7:0]  rec_low;
	logic [2:0]  rec_terms;
	logic        rec_nonempty;
	logic        rec_bad;
	logic [31:0] cfg_tag;
	logic [31:0] cfg_version;

	int errors;
	int burst_left;
	int hold_request;
	int bytes_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A generous watchdog: the slowest legal run is far below this.
	initial begin
		#10_000_000;
		$display("exec_alias_record_parser_test failed");
		$finish;
	end

	// Appends one byte to the end of a byte list.
	task automatic add_byte(ref byte_list_t list, input logic [7:0] b);
		list = {list, b};
	endtask

	task automatic clear_record_state();
		rec_pos = '0;
		rec_tag = '0;
		rec_len = '0;
		rec_version = '0;
		rec_low = '0;
		rec_terms = '0;
		rec_nonempty = 1'b0;
		rec_bad = 1'b0;
	endtask

	// Advances the record state by one accepted byte and queues whatever results it causes.
	task automatic parse_byte(input logic [7:0] b, input logic lst);
		int unsigned p;
		int unsigned cnt;
		logic [15:0] u;
		earp_pkg::verdict_t v;
		parse_result_t res[2];
		int n;
		p = rec_pos;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		// The header fields are gathered little-endian; bytes 6 and 7 are skipped.
		if (p < 4)
			rec_tag = rec_tag | (32'(b) << (8 * p));
		else if (p < 6)
			rec_len = rec_len | (16'(b) << (8 * (p - 4)));
		else if (p >= 8 && p < 12)
			rec_version = rec_version | (32'(b) << (8 * (p - 8)));
		else if (p >= earp_pkg::HEADER_BYTES && p < 32'd8 + 32'(rec_len)) begin
			// Inside the data region, every odd byte completes a UTF-16 unit.
			if (((p - earp_pkg::HEADER_BYTES) & 1) == 0) begin
				rec_low = b;
			end else begin
				u = {b, rec_low};
				if (rec_terms >= 3'd4) begin
					rec_bad = 1'b1;
				end else if (u == 16'h0000) begin
					if (!rec_nonempty)
						rec_bad = 1'b1;
					rec_terms = rec_terms + 3'd1;
					rec_nonempty = 1'b0;
				end else begin
					rec_nonempty = 1'b1;
					// Only the family name and the target path are passed on.
					if (rec_terms == 3'd0 || rec_terms == 3'd2) begin
						res[n].kind = earp_pkg::KIND_UNIT;
						res[n].unit = u;
						res[n].sel = (rec_terms == 3'd2) ?
							earp_pkg::SEL_TARGET : earp_pkg::SEL_FAMILY;
						res[n].verd = earp_pkg::VERDICT_OK;
						n++;
					end
				end
			end
		end
		// The position saturates one past the buffer limit.
		if (p <= earp_pkg::MAX_BUFFER)
			rec_pos = 17'(p + 1);
		cnt = rec_pos;
		if (lst) begin
			if (cnt > earp_pkg::MAX_BUFFER)
				v = earp_pkg::VERDICT_TOO_LONG;
			else if (cnt < earp_pkg::HEADER_BYTES)
				v = earp_pkg::VERDICT_SHORT;
			else if (rec_tag != cfg_tag)
				v = earp_pkg::VERDICT_TAG;
			else if (32'(rec_len) > cnt - 8 || rec_len < 16'd4 || rec_len[0])
				v = earp_pkg::VERDICT_LENGTH;
			else if (rec_version != cfg_version)
				v = earp_pkg::VERDICT_VERSION;
			else if (rec_bad || rec_terms < 3'd4)
				v = earp_pkg::VERDICT_STRINGS;
			else
				v = earp_pkg::VERDICT_OK;
			res[n].kind = earp_pkg::KIND_VERDICT;
			res[n].verd = v;
			n++;
			clear_record_state();
		end
		if (n > 0)
			res[n - 1].eor = 1'b1;
		for (int i = 0; i < n; i++)
			parsed_results_q = {parsed_results_q, res[i]};
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Every popped result item is held against the oldest one still owed.
	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (arst_n && pop && !empty) begin
			if (parsed_results_q.size() == 0) begin
				errors++;
				$display("%0t: result item with nothing owed, expected none, actual kind %0h unit %0h",
					$time, result_kind, code_unit);
			end else begin
				want = parsed_results_q.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(result_kind));
				check_field("code_unit", want.unit, code_unit);
				check_field("string_select", 16'(want.sel), 16'(string_select));
				check_field("verdict", 16'(want.verd), 16'(verdict));
				check_field("end_of_run", 16'(want.eor), 16'(end_of_run));
			end
		end
	end

	// The receiver alternates pop runs and stall runs of random length. A test can ask it
	// to hold off for a counted number of cycles.
	initial begin
		int run_left;
		int hold_left;
		logic pop_on;
		run_left = 0;
		hold_left = 0;
		pop_on = 1'b0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (run_left == 0) begin
					pop_on = !pop_on;
					run_left = pop_on ? $urandom_range(1, 40) : $urandom_range(1, 10);
				end
				run_left--;
				pop <= pop_on;
			end
		end
	end

	// Offers one byte and returns at the clock edge that takes it. Bytes go out in bursts,
	// and a random gap may come before a new burst starts.
	task automatic send_item(input logic [7:0] b, input logic lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		push <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (full);
		parse_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_raw(ref byte_list_t rec);
		foreach (rec[i])
			send_item(rec[i], i == rec.size() - 1);
	endtask

	// Builds the header around a data region and sends the whole record. The length field is
	// the region size plus four, moved by len_adj; trailing bytes follow the region.
	task automatic send_record(input logic [31:0] tag, input logic [31:0] ver,
			ref byte_list_t region, input int len_adj, input int trailing);
		byte_list_t rec;
		logic [15:0] len;
		len = 16'(4 + region.size() + len_adj);
		for (int i = 0; i < 4; i++)
			add_byte(rec, tag[8 * i +: 8]);
		add_byte(rec, len[7:0]);
		add_byte(rec, len[15:8]);
		add_byte(rec, 8'($urandom));
		add_byte(rec, 8'($urandom));
		for (int i = 0; i < 4; i++)
			add_byte(rec, ver[8 * i +: 8]);
		foreach (region[i])
			add_byte(rec, region[i]);
		repeat (trailing) add_byte(rec, 8'($urandom));
		send_raw(rec);
	endtask

	// Nonzero code units, weighted toward ones with a zero byte and the all-ones value.
	function automatic logic [15:0] pick_unit();
		logic [15:0] u;
		case ($urandom_range(0, 7))
			0: u = 16'hFFFF;
			1: u = {8'h00, 8'($urandom_range(1, 255))};
			2: u = {8'($urandom_range(1, 255)), 8'h00};
			default: begin
				u = 16'($urandom);
				if (u == 16'h0000)
					u = 16'h0001;
			end
		endcase
		return u;
	endfunction

	task automatic add_unit(ref byte_list_t region, input logic [15:0] u);
		add_byte(region, u[7:0]);
		add_byte(region, u[15:8]);
	endtask

	// A string of the given number of units followed by its terminator.
	task automatic add_string(ref byte_list_t region, input int units);
		repeat (units) add_unit(region, pick_unit());
		add_unit(region, 16'h0000);
	endtask

	task automatic add_four_strings(ref byte_list_t region, input int max_units);
		repeat (4) add_string(region, $urandom_range(1, max_units));
	endtask

	// Stops sending, waits for every owed result and then lets the parser settle.
	task automatic wait_idle();
		push <= 1'b0;
		while (parsed_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes a register through the APB port and reads it straight back.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			errors++;
			$display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
				$time, idx, value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx == earp_pkg::REG_TAG)
			cfg_tag = value;
		else
			cfg_version = value;
	endtask

	// Records under the reset values of both registers, with the extreme code units.
	task automatic test_default_registers();
		byte_list_t region;
		add_unit(region, 16'hFFFF);
		add_unit(region, 16'h0001);
		add_unit(region, 16'h0000);
		add_unit(region, 16'h00FF);
		add_unit(region, 16'h0000);
		add_unit(region, 16'h0100);
		add_unit(region, 16'h8000);
		add_unit(region, 16'h0000);
		add_unit(region, 16'h7FFF);
		add_unit(region, 16'h0000);
		send_record(earp_pkg::TAG_RESET, earp_pkg::VERSION_RESET, region, 0, 0);
		region.delete();
		add_four_strings(region, 4);
		send_record(earp_pkg::TAG_RESET, earp_pkg::VERSION_RESET, region, 0, 3);
	endtask

	// A single byte, a header cut one byte short, and a bare header with an empty region.
	task automatic test_short_records();
		byte_list_t raw;
		byte_list_t region;
		add_byte(raw, 8'hFF);
		send_raw(raw);
		raw.delete();
		for (int i = 0; i < 11; i++)
			add_byte(raw, 8'($urandom));
		send_raw(raw);
		send_record(cfg_tag, cfg_version, region, 0, 0);
	endtask

	task automatic test_header_faults();
		byte_list_t region;
		add_four_strings(region, 3);
		send_record(cfg_tag ^ 32'h8000_0000, cfg_version, region, 0, 0);
		send_record(cfg_tag, cfg_version, region, -(4 + region.size()), 0);
		send_record(cfg_tag, cfg_version, region, -(2 + region.size()), 0);
		// An odd length that still fits inside the record.
		send_record(cfg_tag, cfg_version, region, -1, 0);
		// A length reaching past the end of the record.
		send_record(cfg_tag, cfg_version, region, 2, 0);
		send_record(cfg_tag, cfg_version ^ 32'h0000_0001, region, 0, 0);
	endtask

	task automatic test_string_faults();
		byte_list_t region;
		// An empty family name.
		add_string(region, 0);
		repeat (3) add_string(region, 2);
		send_record(cfg_tag, cfg_version, region, 0, 0);
		// An empty fourth string.
		region.delete();
		repeat (3) add_string(region, 2);
		add_string(region, 0);
		send_record(cfg_tag, cfg_version, region, 0, 0);
		// Only three strings.
		region.delete();
		repeat (3) add_string(region, 2);
		send_record(cfg_tag, cfg_version, region, 0, 0);
		// A unit, and then a bare terminator, after the fourth string.
		region.delete();
		add_four_strings(region, 2);
		add_unit(region, pick_unit());
		send_record(cfg_tag, cfg_version, region, 0, 0);
		region.delete();
		add_four_strings(region, 2);
		add_unit(region, 16'h0000);
		send_record(cfg_tag, cfg_version, region, 0, 0);
		// The last terminator is missing.
		region.delete();
		add_four_strings(region, 2);
		void'(region.pop_back());
		void'(region.pop_back());
		send_record(cfg_tag, cfg_version, region, 0, 0);
		// Bytes past the region are ignored, so this one is good.
		region.delete();
		add_four_strings(region, 2);
		send_record(cfg_tag, cfg_version, region, 0, 5);
	endtask

	// Both registers at both extremes, a mismatch under a new setting, then random values.
	task automatic test_registers();
		byte_list_t region;
		wait_idle();
		write_reg(earp_pkg::REG_TAG, 32'h0000_0000);
		write_reg(earp_pkg::REG_VERSION, 32'h0000_0000);
		add_four_strings(region, 3);
		send_record(32'h0000_0000, 32'h0000_0000, region, 0, 0);
		send_record(earp_pkg::TAG_RESET, 32'h0000_0000, region, 0, 0);
		wait_idle();
		write_reg(earp_pkg::REG_TAG, 32'hFFFF_FFFF);
		write_reg(earp_pkg::REG_VERSION, 32'hFFFF_FFFF);
		send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, region, 0, 0);
		send_record(32'hFFFF_FFFF, earp_pkg::VERSION_RESET, region, 0, 0);
		wait_idle();
		write_reg(earp_pkg::REG_TAG, $urandom);
		write_reg(earp_pkg::REG_VERSION, $urandom);
		send_record(cfg_tag, cfg_version, region, 0, 0);
	endtask

	// The receiver stops for a long stretch while records keep coming, so the result
	// queue fills and the parser has to stall its input.
	task automatic test_backpressure();
		byte_list_t region;
		wait_idle();
		hold_request = 300;
		repeat (3) begin
			region.delete();
			add_four_strings(region, 5);
			send_record(cfg_tag, cfg_version, region, 0, 0);
		end
		wait_idle();
	endtask

	function automatic logic [31:0] pick_setting(input logic [31:0] dflt);
		case ($urandom_range(0, 3))
			0: return dflt;
			1: return 32'h0000_0000;
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed records with random content; the rest carry one fault each or are
	// plain noise. Every hundred bytes or so the sender drains and the registers change.
	task automatic test_random_records();
		byte_list_t region;
		logic [31:0] t;
		logic [31:0] ver;
		int start;
		int phase_start;
		int mode;
		int len_adj;
		int trailing;
		int k;
		start = bytes_sent;
		phase_start = bytes_sent;
		while (bytes_sent - start < 300) begin
			if (bytes_sent - phase_start >= 100) begin
				wait_idle();
				write_reg(earp_pkg::REG_TAG, pick_setting(earp_pkg::TAG_RESET));
				write_reg(earp_pkg::REG_VERSION, pick_setting(earp_pkg::VERSION_RESET));
				phase_start = bytes_sent;
			end
			region.delete();
			t = cfg_tag;
			ver = cfg_version;
			len_adj = 0;
			trailing = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			mode = $urandom_range(0, 15);
			if (mode == 15) begin
				k = $urandom_range(1, 20);
				repeat (k) add_byte(region, 8'($urandom));
				send_raw(region);
			end else begin
				if (mode == 13) begin
					k = $urandom_range(0, 3);
					for (int i = 0; i < 4; i++)
						add_string(region, (i == k) ? 0 : $urandom_range(1, 4));
				end else begin
					add_four_strings(region, 5);
				end
				case (mode)
					10: t = t ^ (32'h1 << $urandom_range(0, 31));
					11: ver = ver ^ (32'h1 << $urandom_range(0, 31));
					12: len_adj = $urandom_range(0, 6) - 3;
					14: begin
						if ($urandom_range(0, 1) == 0) begin
							add_unit(region, pick_unit());
						end else begin
							void'(region.pop_back());
							void'(region.pop_back());
						end
					end
					default: ;
				endcase
				send_record(t, ver, region, len_adj, trailing);
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		burst_left = 0;
		hold_request = 0;
		bytes_sent = 0;
		cfg_tag = earp_pkg::TAG_RESET;
		cfg_version = earp_pkg::VERSION_RESET;
		clear_record_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_short_records();
		test_header_faults();
		test_string_faults();
		test_registers();
		test_backpressure();
		test_random_records();

		// Give any stray result a chance to show up before the verdict.
		for (int i = 0; i < 20000 && parsed_results_q.size() != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (parsed_results_q.size() != 0) begin
			errors++;
			$display("%0t: results never delivered, expected 0, actual %0d",
				$time, parsed_results_q.size());
		end
		if (errors == 0)
			$display("exec_alias_record_parser_test passed");
		else
			$display("exec_alias_record_parser_test failed");
		$finish;
	end

endmodule
